>>> rtl/core/pfp_pkg.sv
`default_nettype none
package pfp_pkg;

  localparam int FW   = 32;          // field width of coordinates and results
  localparam int EW   = FW + 1;      // edge vector component
  localparam int PW   = 2 * EW;      // edge product, |p| < 2^64
  localparam int NW   = PW;          // cross term, |n| < 2^65 fits signed PW
  localparam int MW   = NW - 1;      // cross term magnitude
  localparam int LW   = $clog2(MW + 1);
  localparam int SW   = 31;          // scaled magnitude width
  localparam int SSW  = 2 * SW + 2;  // sum of three squares
  localparam int RW   = SSW / 2;     // square root width
  localparam int FRAC = 30;          // Q2.30 fraction bits
  localparam int QW   = FRAC + 1;    // quotient width, quotient <= 2^30
  localparam int NUMW = SW + FRAC + 1;
  localparam int OPW  = 2 * FW;      // unit * coordinate
  localparam int OSW  = OPW + 2;     // sum of three products

  localparam int STEPS_PER_STAGE = 2;
  localparam int SQRT_STAGES     = (RW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int DIV_STAGES      = (QW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  typedef logic [2:0][FW-1:0] vec3_t;

  typedef struct packed {
    logic               deg;
    logic [2:0]         neg;
    vec3_t              a;
    logic [2:0][SW-1:0] m;
  } side_t;

  typedef struct packed {
    vec3_t         unit;
    logic [FW-1:0] off;
    logic          deg;
    logic          sat;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/core/pfp_cross.sv
`default_nettype none
module pfp_cross import pfp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  vec3_t               a_i,
  input  vec3_t               b_i,
  input  vec3_t               c_i,
  output logic                vld_o,
  output logic [2:0][MW-1:0]  mag_o,
  output logic [2:0]          neg_o,
  output vec3_t               a_o
);

  logic [3:0]            vld_r;
  vec3_t                 a1_r, a2_r, a3_r, a4_r;
  logic signed [EW-1:0]  e1_r [3];
  logic signed [EW-1:0]  e2_r [3];
  logic signed [PW-1:0]  p_r [3];
  logic signed [PW-1:0]  q_r [3];
  logic signed [NW-1:0]  n_r [3];
  logic [2:0][MW-1:0]    mag_r;
  logic [2:0]            neg_r;
  logic signed [NW-1:0]  nn [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nn[i] = -n_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld_i};
      // edges from the first point
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= $signed({b_i[i][FW-1], b_i[i]}) - $signed({a_i[i][FW-1], a_i[i]});
        e2_r[i] <= $signed({c_i[i][FW-1], c_i[i]}) - $signed({a_i[i][FW-1], a_i[i]});
      end
      a1_r <= a_i;
      // cross product partial products
      p_r[0] <= e1_r[1] * e2_r[2];
      q_r[0] <= e1_r[2] * e2_r[1];
      p_r[1] <= e1_r[2] * e2_r[0];
      q_r[1] <= e1_r[0] * e2_r[2];
      p_r[2] <= e1_r[0] * e2_r[1];
      q_r[2] <= e1_r[1] * e2_r[0];
      a2_r <= a1_r;
      for (int i = 0; i < 3; i++) begin
        n_r[i] <= p_r[i] - q_r[i];
      end
      a3_r <= a2_r;
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= n_r[i][NW-1];
        mag_r[i] <= n_r[i][NW-1] ? nn[i][MW-1:0] : n_r[i][MW-1:0];
      end
      a4_r <= a3_r;
    end
  end

  assign vld_o = vld_r[3];
  assign mag_o = mag_r;
  assign neg_o = neg_r;
  assign a_o   = a4_r;

endmodule
`default_nettype wire

>>> rtl/core/pfp_norm.sv
`default_nettype none
module pfp_norm import pfp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic [2:0][MW-1:0] mag_i,
  input  logic [2:0]         neg_i,
  input  vec3_t              a_i,
  output logic               vld_o,
  output logic [SSW-1:0]     s_o,
  output side_t              side_o
);

  logic [3:0]             vld_r;
  logic [2:0][MW-1:0]     mag_r;
  logic [2:0]             neg_r;
  vec3_t                  a_r;
  logic [LW-1:0]          len_r;
  side_t                  sf_r, sg_r, sh_r;
  logic [2*SW-1:0]        sq_r [3];
  logic [SSW-1:0]         s_r;

  logic [MW-1:0]          mag_or;
  logic [LW-1:0]          len_c;
  logic [LW-1:0]          sh;
  logic [2:0][SW-1:0]     m_c;

  // bit length of the largest magnitude
  always_comb begin
    mag_or = mag_i[0] | mag_i[1] | mag_i[2];
    len_c  = '0;
    for (int k = 0; k < MW; k++) begin
      if (mag_or[k]) len_c = LW'(k + 1);
    end
  end

  // common shift bringing the largest magnitude to SW bits
  always_comb begin
    if (len_r > LW'(SW)) begin
      sh = len_r - LW'(SW);
      for (int i = 0; i < 3; i++) m_c[i] = SW'(mag_r[i] >> sh);
    end else begin
      sh = LW'(SW) - len_r;
      for (int i = 0; i < 3; i++) m_c[i] = SW'(mag_r[i] << sh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld_i};
      mag_r <= mag_i;
      neg_r <= neg_i;
      a_r   <= a_i;
      len_r <= len_c;
      sf_r.deg <= (len_r == '0);
      sf_r.neg <= neg_r;
      sf_r.a   <= a_r;
      sf_r.m   <= m_c;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= (2*SW)'(sf_r.m[i]) * (2*SW)'(sf_r.m[i]);
      end
      sg_r <= sf_r;
      s_r  <= SSW'(sq_r[0]) + SSW'(sq_r[1]) + SSW'(sq_r[2]);
      sh_r <= sg_r;
    end
  end

  assign vld_o  = vld_r[3];
  assign s_o    = s_r;
  assign side_o = sh_r;

endmodule
`default_nettype wire

>>> rtl/core/pfp_sqrt.sv
`default_nettype none
module pfp_sqrt import pfp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  logic [SSW-1:0] s_i,
  input  side_t          side_i,
  output logic           vld_o,
  output logic [RW-1:0]  root_o,
  output side_t          side_o
);

  localparam int REMW = RW + 2;

  logic             vld_r  [1:SQRT_STAGES];
  logic [REMW-1:0]  rem_r  [1:SQRT_STAGES];
  logic [RW-1:0]    root_r [1:SQRT_STAGES];
  logic [SSW-1:0]   x_r    [1:SQRT_STAGES];
  side_t            side_r [1:SQRT_STAGES];

  // restoring square root, two result bits per stage
  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    logic            vld_in;
    logic [REMW-1:0] rem_in, rem_nxt;
    logic [RW-1:0]   root_in, root_nxt;
    logic [SSW-1:0]  x_in, x_nxt;
    side_t           side_in;
    logic [REMW+1:0] t, trial;

    if (g == 0) begin : g_src
      assign vld_in  = vld_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = s_i;
      assign side_in = side_i;
    end else begin : g_src
      assign vld_in  = vld_r[g];
      assign rem_in  = rem_r[g];
      assign root_in = root_r[g];
      assign x_in    = x_r[g];
      assign side_in = side_r[g];
    end

    always_comb begin
      rem_nxt  = rem_in;
      root_nxt = root_in;
      x_nxt    = x_in;
      t        = '0;
      trial    = '0;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        if (g * STEPS_PER_STAGE + k < RW) begin
          t     = {rem_nxt, x_nxt[SSW-1 -: 2]};
          trial = {2'b00, root_nxt, 2'b01};
          if (t >= trial) begin
            t        = t - trial;
            root_nxt = {root_nxt[RW-2:0], 1'b1};
          end else begin
            root_nxt = {root_nxt[RW-2:0], 1'b0};
          end
          rem_nxt = t[REMW-1:0];
          x_nxt   = {x_nxt[SSW-3:0], 2'b00};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else if (en) begin
        vld_r[g+1]  <= vld_in;
        rem_r[g+1]  <= rem_nxt;
        root_r[g+1] <= root_nxt;
        x_r[g+1]    <= x_nxt;
        side_r[g+1] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[SQRT_STAGES];
  assign root_o = root_r[SQRT_STAGES];
  assign side_o = side_r[SQRT_STAGES];

endmodule
`default_nettype wire

>>> rtl/core/pfp_div.sv
`default_nettype none
module pfp_div import pfp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic [RW-1:0]      root_i,
  input  side_t              side_i,
  output logic               vld_o,
  output logic [2:0][QW-1:0] q_o,
  output side_t              side_o
);

  // prep stage: rounded numerators, divisor never zero
  logic               vld_p_r;
  logic [RW-1:0]      d_p_r;
  logic [2:0][RW-1:0] rem_p_r;
  logic [2:0][QW-1:0] low_p_r;
  side_t              side_p_r;
  logic [NUMW-1:0]    num_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_c[i] = (NUMW'(side_i.m[i]) << FRAC) + NUMW'(root_i >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_p_r <= 1'b0;
    end else if (en) begin
      vld_p_r  <= vld_i;
      d_p_r    <= (root_i == '0) ? RW'(1) : root_i;
      side_p_r <= side_i;
      for (int i = 0; i < 3; i++) begin
        rem_p_r[i] <= RW'(num_c[i][NUMW-1:QW]);
        low_p_r[i] <= num_c[i][QW-1:0];
      end
    end
  end

  logic               vld_r  [1:DIV_STAGES];
  logic [RW-1:0]      d_r    [1:DIV_STAGES];
  logic [2:0][RW-1:0] rem_r  [1:DIV_STAGES];
  logic [2:0][QW-1:0] low_r  [1:DIV_STAGES];
  logic [2:0][QW-1:0] q_r    [1:DIV_STAGES];
  side_t              side_r [1:DIV_STAGES];

  // restoring division, three lanes, two quotient bits per stage
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic               vld_in;
    logic [RW-1:0]      d_in;
    logic [2:0][RW-1:0] rem_in, rem_nxt;
    logic [2:0][QW-1:0] low_in, low_nxt, q_in, q_nxt;
    side_t              side_in;
    logic [RW:0]        t;

    if (g == 0) begin : g_src
      assign vld_in  = vld_p_r;
      assign d_in    = d_p_r;
      assign rem_in  = rem_p_r;
      assign low_in  = low_p_r;
      assign q_in    = '0;
      assign side_in = side_p_r;
    end else begin : g_src
      assign vld_in  = vld_r[g];
      assign d_in    = d_r[g];
      assign rem_in  = rem_r[g];
      assign low_in  = low_r[g];
      assign q_in    = q_r[g];
      assign side_in = side_r[g];
    end

    always_comb begin
      rem_nxt = rem_in;
      low_nxt = low_in;
      q_nxt   = q_in;
      t       = '0;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
          if (g * STEPS_PER_STAGE + k < QW) begin
            t = {rem_nxt[i], low_nxt[i][QW-1]};
            if (t >= {1'b0, d_in}) begin
              t        = t - {1'b0, d_in};
              q_nxt[i] = {q_nxt[i][QW-2:0], 1'b1};
            end else begin
              q_nxt[i] = {q_nxt[i][QW-2:0], 1'b0};
            end
            rem_nxt[i] = t[RW-1:0];
            low_nxt[i] = {low_nxt[i][QW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else if (en) begin
        vld_r[g+1]  <= vld_in;
        d_r[g+1]    <= d_in;
        rem_r[g+1]  <= rem_nxt;
        low_r[g+1]  <= low_nxt;
        q_r[g+1]    <= q_nxt;
        side_r[g+1] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[DIV_STAGES];
  assign q_o    = q_r[DIV_STAGES];
  assign side_o = side_r[DIV_STAGES];

endmodule
`default_nettype wire

>>> rtl/core/pfp_offset.sv
`default_nettype none
module pfp_offset import pfp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic [2:0][QW-1:0] q_i,
  input  side_t              side_i,
  output logic               vld_o,
  output res_t               res_o
);

  localparam int RNDW = OSW - FRAC;

  logic [4:0]            vld_r;
  vec3_t                 u1_r, u2_r, u3_r, u4_r;
  vec3_t                 a1_r;
  logic [3:0]            deg_r;
  logic signed [OPW-1:0] prod_r [3];
  logic signed [OSW-1:0] sum_r;
  logic                  sneg_r;
  logic [OSW-1:0]        amag_r;
  res_t                  res_r;

  logic [FW-1:0]         upos [3];
  logic [FW-1:0]         uneg [3];
  logic signed [OSW-1:0] sum_neg;
  logic [OSW-1:0]        rnd_full;
  logic [RNDW-1:0]       rnd;
  logic [RNDW-1:0]       rnd_neg;
  logic [FW-1:0]         off_c;
  logic                  sat_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      upos[i] = {1'b0, q_i[i]};
      uneg[i] = -upos[i];
    end
  end

  assign sum_neg = -sum_r;

  // round half away from zero, then clamp
  always_comb begin
    rnd_full = amag_r + (OSW'(1) << (FRAC - 1));
    rnd      = rnd_full[OSW-1:FRAC];
    rnd_neg  = -rnd;
    sat_c    = 1'b0;
    if (sneg_r) begin
      if (rnd > (RNDW'(1) << (FW - 1))) begin
        off_c = {1'b1, {(FW-1){1'b0}}};
        sat_c = 1'b1;
      end else begin
        off_c = rnd_neg[FW-1:0];
      end
    end else begin
      if (rnd > RNDW'({1'b0, {(FW-1){1'b1}}})) begin
        off_c = {1'b0, {(FW-1){1'b1}}};
        sat_c = 1'b1;
      end else begin
        off_c = rnd[FW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], vld_i};
      deg_r <= {deg_r[2:0], side_i.deg};
      for (int i = 0; i < 3; i++) begin
        u1_r[i] <= side_i.neg[i] ? uneg[i] : upos[i];
      end
      a1_r <= side_i.a;
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= $signed(u1_r[i]) * $signed(a1_r[i]);
      end
      u2_r  <= u1_r;
      sum_r <= OSW'(prod_r[0]) + OSW'(prod_r[1]) + OSW'(prod_r[2]);
      u3_r  <= u2_r;
      sneg_r <= sum_r[OSW-1];
      amag_r <= sum_r[OSW-1] ? sum_neg : sum_r;
      u4_r   <= u3_r;
      res_r.unit <= u4_r;
      res_r.off  <= off_c;
      res_r.sat  <= sat_c;
      res_r.deg  <= deg_r[3];
    end
  end

  assign vld_o = vld_r[4];
  assign res_o = res_r;

endmodule
`default_nettype wire

>>> rtl/core/plane_from_three_points_unit.sv
// Plane through three points: unit normal (Q2.30) and offset (Q32.0 integer).
// Stages in order: cross, scale, square root, divide, offset, output register.
// Throughput: one request per cycle while in_stall is low; every stage is a
// register, the square root and the divider resolve two bits per stage.
// Reset: synchronous active-low rst_n clears all valid bits and the skid buffer.
`default_nettype none
module plane_from_three_points_unit import pfp_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [FW-1:0] in_a_x,
  input  logic signed [FW-1:0] in_a_y,
  input  logic signed [FW-1:0] in_a_z,
  input  logic signed [FW-1:0] in_b_x,
  input  logic signed [FW-1:0] in_b_y,
  input  logic signed [FW-1:0] in_b_z,
  input  logic signed [FW-1:0] in_c_x,
  input  logic signed [FW-1:0] in_c_y,
  input  logic signed [FW-1:0] in_c_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [FW-1:0] out_unit_nx,
  output logic signed [FW-1:0] out_unit_ny,
  output logic signed [FW-1:0] out_unit_nz,
  output logic signed [FW-1:0] out_plane_offset,
  output logic                 out_degenerate,
  output logic                 out_offset_saturated
);

  // only the low CW_EFF bits of each coordinate count, sign-extended
  localparam int CW_EFF = (COORD_WIDTH > FW) ? FW : ((COORD_WIDTH < 1) ? 1 : COORD_WIDTH);

  function automatic logic [FW-1:0] sext(input logic [FW-1:0] v);
    logic signed [CW_EFF-1:0] t;
    t = v[CW_EFF-1:0];
    return FW'(t);
  endfunction

  // whole pipeline advances together; the skid register absorbs the one
  // result that arrives while the output is held
  logic  en;
  logic  skid_vld_r, out_vld_r;
  res_t  skid_r, out_r;

  vec3_t a_c, b_c, c_c;

  assign a_c = {sext(in_a_z), sext(in_a_y), sext(in_a_x)};
  assign b_c = {sext(in_b_z), sext(in_b_y), sext(in_b_x)};
  assign c_c = {sext(in_c_z), sext(in_c_y), sext(in_c_x)};

  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r;

  // cross product of the edge vectors b - a and c - a, exact
  logic               cr_vld;
  logic [2:0][MW-1:0] cr_mag;
  logic [2:0]         cr_neg;
  vec3_t              cr_a;

  pfp_cross u_cross (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_valid),
    .a_i   (a_c),
    .b_i   (b_c),
    .c_i   (c_c),
    .vld_o (cr_vld),
    .mag_o (cr_mag),
    .neg_o (cr_neg),
    .a_o   (cr_a)
  );

  // scale to 31 bits, sum of squares
  logic           nm_vld;
  logic [SSW-1:0] nm_s;
  side_t          nm_side;

  pfp_norm u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (cr_vld),
    .mag_i  (cr_mag),
    .neg_i  (cr_neg),
    .a_i    (cr_a),
    .vld_o  (nm_vld),
    .s_o    (nm_s),
    .side_o (nm_side)
  );

  // vector length
  logic          sq_vld;
  logic [RW-1:0] sq_root;
  side_t         sq_side;

  pfp_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (nm_vld),
    .s_i    (nm_s),
    .side_i (nm_side),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // unit magnitudes, rounded
  logic               dv_vld;
  logic [2:0][QW-1:0] dv_q;
  side_t              dv_side;

  pfp_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (sq_vld),
    .root_i (sq_root),
    .side_i (sq_side),
    .vld_o  (dv_vld),
    .q_o    (dv_q),
    .side_o (dv_side)
  );

  // signs, dot with first point, round and clamp
  logic pipe_vld;
  res_t pipe_res;

  pfp_offset u_offset (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (dv_vld),
    .q_i    (dv_q),
    .side_i (dv_side),
    .vld_o  (pipe_vld),
    .res_o  (pipe_res)
  );

  // output register plus skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_vld_r && out_stall) begin
      if (en && pipe_vld) begin
        skid_vld_r <= 1'b1;
        skid_r     <= pipe_res;
      end
    end else if (skid_vld_r) begin
      out_vld_r  <= 1'b1;
      out_r      <= skid_r;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r <= pipe_vld;
      out_r     <= pipe_res;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_unit_nx          = out_r.unit[0];
  assign out_unit_ny          = out_r.unit[1];
  assign out_unit_nz          = out_r.unit[2];
  assign out_plane_offset     = out_r.off;
  assign out_degenerate       = out_r.deg;
  assign out_offset_saturated = out_r.sat;

endmodule
`default_nettype wire
